@@ hw/rtl/tobpl_pkg.sv @@
// Shared types and constants for the top-of-book price level tables.
// Used by tobpl_ctrl, tobpl_side, tobpl_datapath and the top level.
package tobpl_pkg;

    localparam int LEVELS     = 16;
    localparam int PRICE_W    = 32;
    localparam int QTY_IN_W   = 32;
    localparam int QTY_W      = 31;
    localparam int GRP_SIZE   = 4;
    localparam int NUM_GRP    = (LEVELS + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef struct packed {
        logic capture;
        logic write;
        logic tree1;
        logic tree2;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } lvl_t;

    // Keep a unless b is valid and strictly better for this side.
    function automatic lvl_t best_of(lvl_t a, lvl_t b, logic want_min);
        logic better;
        begin
            better = want_min ? (b.price < a.price) : (b.price > a.price);
            if (b.valid && (!a.valid || better))
                best_of = b;
            else
                best_of = a;
        end
    endfunction

endpackage

@@ hw/rtl/tobpl_ctrl.sv @@
// Controller for the price level tables: one request in flight at a time.
// Depends on tobpl_pkg for the command struct.
module tobpl_ctrl
    import tobpl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WRITE = 4'b0010,
        ST_TREE1 = 4'b0100,
        ST_TREE2 = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_WRITE;
            end
            ST_WRITE: state_next = ST_TREE1;
            ST_TREE1: state_next = ST_TREE2;
            ST_TREE2: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cmd.capture = start && !busy;
    assign cmd.write   = (state_reg == ST_WRITE);
    assign cmd.tree1   = (state_reg == ST_TREE1);
    assign cmd.tree2   = (state_reg == ST_TREE2);
    assign done_next   = cmd.tree2;
    assign done        = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

@@ hw/rtl/tobpl_side.sv @@
// One side's level table: price match at capture, update, and a two-stage
// best-level tree (highest price for bids, lowest for asks). Uses tobpl_pkg.
module tobpl_side
    import tobpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ask_side,
    input  cmd_t                cmd,
    input  logic                operation,
    input  logic [PRICE_W-1:0]  price,
    input  logic [QTY_IN_W-1:0] quantity,
    output logic                best_valid,
    output logic [PRICE_W-1:0]  best_price,
    output logic [QTY_W-1:0]    best_qty,
    output logic                dropped
);

    logic [PRICE_W-1:0] lvl_price_reg [LEVELS];
    logic [QTY_W-1:0]   lvl_qty_reg   [LEVELS];
    logic [LEVELS-1:0]  used_reg, used_next;

    logic [PRICE_W-1:0] px_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic               pos_reg, sel_reg;
    logic [LEVELS-1:0]  hit_reg, free_reg;
    logic [LEVELS-1:0]  hit_raw, free_raw, hit_next, free_next;

    lvl_t grp_reg [NUM_GRP];
    lvl_t grp_next [NUM_GRP];
    lvl_t best_reg, best_next;
    logic dropped_reg, dropped_next;

    // Match against the incoming price; keep the first hit and first free slot.
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            hit_raw[i]  = used_reg[i] && (lvl_price_reg[i] == price);
            free_raw[i] = !used_reg[i];
        end
        hit_next  = hit_raw & (~hit_raw + LEVELS'(1));
        free_next = free_raw & (~free_raw + LEVELS'(1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg   <= price;
            qty_reg  <= quantity[QTY_W-1:0];
            pos_reg  <= !quantity[QTY_IN_W-1] && (quantity != '0);
            sel_reg  <= (operation == ask_side);
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    // Update: qty <= 0 frees hit, else rewrite hit qty or fill a free slot.
    always_comb
    begin
        used_next    = used_reg;
        dropped_next = dropped_reg;
        if (cmd.write)
        begin
            dropped_next = 1'b0;
            if (sel_reg)
            begin
                if (!pos_reg)
                    used_next = used_reg & ~hit_reg;
                else if (hit_reg == '0)
                begin
                    used_next    = used_reg | free_reg;
                    dropped_next = (free_reg == '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            if (cmd.write && sel_reg && pos_reg)
            begin
                if (hit_reg[i])
                    lvl_qty_reg[i] <= qty_reg;
                else if (hit_reg == '0 && free_reg[i])
                begin
                    lvl_price_reg[i] <= px_reg;
                    lvl_qty_reg[i]   <= qty_reg;
                end
            end
        end
    end

    // First tree stage: reduce each group of entries.
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                if (g * GRP_SIZE + k < LEVELS)
                    grp_next[g] = best_of(grp_next[g],
                        '{valid: used_reg[g * GRP_SIZE + k],
                          price: lvl_price_reg[g * GRP_SIZE + k],
                          qty:   lvl_qty_reg[g * GRP_SIZE + k]},
                        ask_side);
            end
        end
    end

    // Second tree stage: reduce the group winners.
    always_comb
    begin
        best_next = '0;
        for (int g = 0; g < NUM_GRP; g++)
            best_next = best_of(best_next, grp_reg[g], ask_side);
        if (!best_next.valid)
            best_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tree1)
            grp_reg <= grp_next;
        if (cmd.tree2)
            best_reg <= best_next;
    end

    assign best_valid = best_reg.valid;
    assign best_price = best_reg.price;
    assign best_qty   = best_reg.qty;
    assign dropped    = dropped_reg;

endmodule

@@ hw/rtl/tobpl_datapath.sv @@
// Datapath: bid and ask level tables and the merged drop flag.
// Depends on tobpl_pkg and tobpl_side.
module tobpl_datapath
    import tobpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                operation,
    input  logic [PRICE_W-1:0]  price,
    input  logic [QTY_IN_W-1:0] quantity,
    output logic                best_bid_valid,
    output logic [PRICE_W-1:0]  best_bid_price,
    output logic [QTY_W-1:0]    best_bid_qty,
    output logic                best_ask_valid,
    output logic [PRICE_W-1:0]  best_ask_price,
    output logic [QTY_W-1:0]    best_ask_qty,
    output logic                level_dropped
);

    logic bid_dropped, ask_dropped;

    tobpl_side u_bid (
        .clk        (clk),
        .rst_n      (rst_n),
        .ask_side   (SIDE_BID),
        .cmd        (cmd),
        .operation  (operation),
        .price      (price),
        .quantity   (quantity),
        .best_valid (best_bid_valid),
        .best_price (best_bid_price),
        .best_qty   (best_bid_qty),
        .dropped    (bid_dropped)
    );

    tobpl_side u_ask (
        .clk        (clk),
        .rst_n      (rst_n),
        .ask_side   (SIDE_ASK),
        .cmd        (cmd),
        .operation  (operation),
        .price      (price),
        .quantity   (quantity),
        .best_valid (best_ask_valid),
        .best_price (best_ask_price),
        .best_qty   (best_ask_qty),
        .dropped    (ask_dropped)
    );

    // Only the updated side can refuse a level.
    assign level_dropped = bid_dropped | ask_dropped;

endmodule

@@ hw/rtl/top_of_book_price_levels.sv @@
// Top-of-book price level tables: bid and ask tables of LEVELS entries each.
// A request is taken when start is high and busy is low; the result follows
// on a one-cycle done strobe, and the receiver cannot stall it. A new
// request can be taken in the cycle done is high; each request passes in
// order through capture/match, table update, group reduction and final
// reduction of the best-level tree, and done is registered after the last.
// Depends on tobpl_pkg, tobpl_ctrl and tobpl_datapath.
module top_of_book_price_levels
    import tobpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                operation,
    input  logic [PRICE_W-1:0]  price,
    input  logic [QTY_IN_W-1:0] quantity,
    output logic                done,
    output logic                best_bid_valid,
    output logic [PRICE_W-1:0]  best_bid_price,
    output logic [QTY_W-1:0]    best_bid_qty,
    output logic                best_ask_valid,
    output logic [PRICE_W-1:0]  best_ask_price,
    output logic [QTY_W-1:0]    best_ask_qty,
    output logic                level_dropped
);

    cmd_t cmd;

    tobpl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    tobpl_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .operation      (operation),
        .price          (price),
        .quantity       (quantity),
        .best_bid_valid (best_bid_valid),
        .best_bid_price (best_bid_price),
        .best_bid_qty   (best_bid_qty),
        .best_ask_valid (best_ask_valid),
        .best_ask_price (best_ask_price),
        .best_ask_qty   (best_ask_qty),
        .level_dropped  (level_dropped)
    );

endmodule
